// ===== design/tdsd_pkg.sv =====
`timescale 1ns / 1ps

package tdsd_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [6:0] pattern_type;
   typedef pattern_type [2:0] patterns_type;

   localparam cmd_type CMD_NUMBER = 2'd0;
   localparam cmd_type CMD_TEMP   = 2'd1;
   localparam cmd_type CMD_RAW    = 2'd2;
   localparam cmd_type CMD_SCAN   = 2'd3;

   localparam pattern_type PAT_BLANK = 7'h00;
   localparam pattern_type PAT_C     = 7'h39;
   localparam pattern_type SEG_OFF   = 7'h7F;
   localparam logic [2:0]  DIG_OFF   = 3'b111;

   localparam logic [15:0] NUM_MAX  = 16'd999;
   localparam logic [15:0] TEMP_MAX = 16'd99;

   localparam patterns_type PATTERNS_RESET = {7'h3F, 7'h00, 7'h00};

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] value;
      logic        blank_leading;
      pattern_type raw_left;
      pattern_type raw_middle;
      pattern_type raw_right;
   } req_word_type;

   typedef struct packed {
      logic fire;
      logic load;
      logic tick;
   } step_type;

   function automatic pattern_type seg_of(input logic [3:0] digit);
      pattern_type pat;
      case (digit)
         4'd0:    pat = 7'h3F;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5B;
         4'd3:    pat = 7'h4F;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6D;
         4'd6:    pat = 7'h7D;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7F;
         4'd9:    pat = 7'h6F;
         default: pat = PAT_BLANK;
      endcase
      return pat;
   endfunction

endpackage

// ===== design/tdsd_req_if.sv =====
`timescale 1ns / 1ps

interface tdsd_req_if;
   logic                 valid;
   logic                 ready;
   tdsd_pkg::cmd_type    cmd;
   logic [15:0]          value;
   logic                 blank_leading;
   tdsd_pkg::pattern_type raw_left;
   tdsd_pkg::pattern_type raw_middle;
   tdsd_pkg::pattern_type raw_right;

   modport source (output valid, cmd, value, blank_leading, raw_left, raw_middle, raw_right,
                   input ready);
   modport sink (input valid, cmd, value, blank_leading, raw_left, raw_middle, raw_right,
                 output ready);
endinterface

// ===== design/tdsd_rsp_if.sv =====
`timescale 1ns / 1ps

interface tdsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] segment_lines;
   logic [2:0] digit_enables;

   modport source (output valid, segment_lines, digit_enables, input ready);
   modport sink (input valid, segment_lines, digit_enables, output ready);
endinterface

// ===== design/three_digit_seven_segment_driver_top.sv =====
`timescale 1ns / 1ps

// Three-digit multiplexed seven-segment driver. Each request word is a number
// load (clamped to 999, optional leading-zero blanking), a temperature load
// (clamped to 99, "C" in the right digit), a raw pattern load, or a scan tick
// that lights the next digit (left, middle, right, then wrap). Loads change
// only the stored patterns; every word returns one response holding the
// active-low segment and digit pins after that word. One word per cycle while
// neither side stalls: a word is held in the input register, formatted there,
// and lands in the pin/response register once that register is free.
// Both sides may stall freely; while a response waits the input register takes
// at most one more word, then request ready stays low until the response drains.

module three_digit_seven_segment_driver_top (
   input logic        clock,
   input logic        reset,
   tdsd_req_if.sink   req_chan,
   tdsd_rsp_if.source rsp_chan
);

   tdsd_pkg::req_word_type word_ff;
   tdsd_pkg::req_word_type word_in;
   logic                   word_valid_ff;
   logic                   word_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   advance;
   logic                   take;
   tdsd_pkg::step_type     step;
   tdsd_pkg::patterns_type patterns;
   logic                   load;
   logic                   tick;

   assign advance = word_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !word_valid_ff || advance;

   always_comb begin
      word_in       = word_ff;
      word_valid_in = word_valid_ff && !advance;
      if (take) begin
         word_in.cmd           = req_chan.cmd;
         word_in.value         = req_chan.value;
         word_in.blank_leading = req_chan.blank_leading;
         word_in.raw_left      = req_chan.raw_left;
         word_in.raw_middle    = req_chan.raw_middle;
         word_in.raw_right     = req_chan.raw_right;
         word_valid_in         = 1'b1;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   tdsd_format u_format (
      .word     (word_ff),
      .load     (load),
      .tick     (tick),
      .patterns (patterns)
   );

   assign step.fire = advance;
   assign step.load = load;
   assign step.tick = tick;

   tdsd_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .patterns_in   (patterns),
      .segment_lines (rsp_chan.segment_lines),
      .digit_enables (rsp_chan.digit_enables)
   );

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

// ===== design/tdsd_format.sv =====
`timescale 1ns / 1ps

module tdsd_format (
   input  tdsd_pkg::req_word_type word,
   output logic                   load,
   output logic                   tick,
   output tdsd_pkg::patterns_type patterns
);

   logic [9:0]  num;
   logic [15:0] hund_prod;
   logic [3:0]  hund;
   logic [9:0]  hund_x100;
   logic [6:0]  num_rem;
   logic [14:0] num_tens_prod;
   logic [3:0]  num_tens;
   logic [6:0]  num_tens_x10;
   logic [3:0]  num_units;

   logic [6:0]  temp;
   logic [14:0] temp_tens_prod;
   logic [3:0]  temp_tens;
   logic [6:0]  temp_tens_x10;
   logic [3:0]  temp_units;

   // n/100 as (n*41)>>12 and r/10 as (r*205)>>11, exact over the clamped ranges
   always_comb begin
      num           = (word.value > tdsd_pkg::NUM_MAX) ? 10'(tdsd_pkg::NUM_MAX)
                                                       : word.value[9:0];
      hund_prod     = 16'(num) * 16'd41;
      hund          = hund_prod[15:12];
      hund_x100     = 10'(hund) * 10'd100;
      num_rem       = 7'(num - hund_x100);
      num_tens_prod = 15'(num_rem) * 15'd205;
      num_tens      = num_tens_prod[14:11];
      num_tens_x10  = 7'(num_tens) * 7'd10;
      num_units     = 4'(num_rem - num_tens_x10);

      temp           = (word.value > tdsd_pkg::TEMP_MAX) ? 7'(tdsd_pkg::TEMP_MAX)
                                                         : word.value[6:0];
      temp_tens_prod = 15'(temp) * 15'd205;
      temp_tens      = temp_tens_prod[14:11];
      temp_tens_x10  = 7'(temp_tens) * 7'd10;
      temp_units     = 4'(temp - temp_tens_x10);
   end

   always_comb begin
      load     = 1'b1;
      tick     = 1'b0;
      patterns = tdsd_pkg::PATTERNS_RESET;
      unique case (word.cmd)
         tdsd_pkg::CMD_NUMBER: begin
            patterns[0] = (word.blank_leading && hund == 4'd0) ? tdsd_pkg::PAT_BLANK
                                                               : tdsd_pkg::seg_of(hund);
            patterns[1] = (word.blank_leading && hund == 4'd0 && num_tens == 4'd0)
                          ? tdsd_pkg::PAT_BLANK : tdsd_pkg::seg_of(num_tens);
            patterns[2] = tdsd_pkg::seg_of(num_units);
         end
         tdsd_pkg::CMD_TEMP: begin
            patterns[0] = tdsd_pkg::seg_of(temp_tens);
            patterns[1] = tdsd_pkg::seg_of(temp_units);
            patterns[2] = tdsd_pkg::PAT_C;
         end
         tdsd_pkg::CMD_RAW: begin
            patterns[0] = word.raw_left;
            patterns[1] = word.raw_middle;
            patterns[2] = word.raw_right;
         end
         tdsd_pkg::CMD_SCAN: begin
            load = 1'b0;
            tick = 1'b1;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/tdsd_scan.sv =====
`timescale 1ns / 1ps

module tdsd_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  tdsd_pkg::step_type     step,
   input  tdsd_pkg::patterns_type patterns_in,
   output logic [6:0]             segment_lines,
   output logic [2:0]             digit_enables
);

   tdsd_pkg::patterns_type patterns_ff;
   tdsd_pkg::patterns_type patterns_in_sel;
   logic [1:0]             scan_ff;
   logic [1:0]             scan_in;
   logic [1:0]             pos;
   logic [6:0]             seg_ff;
   logic [6:0]             seg_in;
   logic [2:0]             dig_ff;
   logic [2:0]             dig_in;

   // a stray position of 3 behaves as the right digit
   always_comb begin
      pos             = (scan_ff == 2'd3) ? 2'd2 : scan_ff;
      patterns_in_sel = patterns_ff;
      scan_in         = scan_ff;
      seg_in          = seg_ff;
      dig_in          = dig_ff;
      if (step.fire && step.load) begin
         patterns_in_sel = patterns_in;
      end
      if (step.fire && step.tick) begin
         seg_in  = ~patterns_ff[pos];
         dig_in  = ~(3'b001 << pos);
         scan_in = (pos == 2'd2) ? 2'd0 : 2'(pos + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         patterns_ff <= tdsd_pkg::PATTERNS_RESET;
         scan_ff     <= 2'd0;
         seg_ff      <= tdsd_pkg::SEG_OFF;
         dig_ff      <= tdsd_pkg::DIG_OFF;
      end else begin
         patterns_ff <= patterns_in_sel;
         scan_ff     <= scan_in;
         seg_ff      <= seg_in;
         dig_ff      <= dig_in;
      end
   end

   assign segment_lines = seg_ff;
   assign digit_enables = dig_ff;

endmodule

// ===== design/tdsd_checker.sv =====
`timescale 1ns / 1ps

module tdsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] segment_lines,
   input logic [2:0] digit_enables
);

   // at most one digit lit
   assert property (@(posedge clock) disable iff (reset)
      $countones(~digit_enables) <= 1)
      else $error("more than one digit enabled");

   // no segments driven before the first scan tick
   assert property (@(posedge clock) disable iff (reset)
      (digit_enables == 3'b111) |-> (segment_lines == 7'h7F))
      else $error("segments driven with no digit enabled");

   // scan order: left is followed by middle
   assert property (@(posedge clock) disable iff (reset)
      ($past(digit_enables) == 3'b110 && digit_enables != 3'b110)
      |-> (digit_enables == 3'b101))
      else $error("scan order broken after left digit");

   // an empty response register never holds off requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(segment_lines) && $stable(digit_enables)))
      else $error("stalled response word changed");

endmodule

bind three_digit_seven_segment_driver_top tdsd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .segment_lines (rsp_chan.segment_lines),
   .digit_enables (rsp_chan.digit_enables)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      tdsd_pkg::pattern_type segs;
      logic [2:0]            digs;
   } pins_type;

   // digit glyphs 9..0, seven bits each, bit0 segment a
   localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                     7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

   logic clock;
   logic reset = 1'b1;

   tdsd_req_if req_chan ();
   tdsd_rsp_if rsp_chan ();

   three_digit_seven_segment_driver_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tdsd_pkg::pattern_type shown [3];
   logic [1:0]            scan_at;
   tdsd_pkg::pattern_type seg_pins;
   logic [2:0]            dig_pins;
   pins_type              pin_queue [$];
   int unsigned           errors = 0;
   bit                    req_calm = 1'b0;
   bit                    rsp_calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** three_digit_seven_segment_driver_top: FAILED **");
      $finish;
   end

   function automatic tdsd_pkg::pattern_type glyph(input int unsigned d);
      return GLYPHS[d * 7 +: 7];
   endfunction

   function automatic tdsd_pkg::req_word_type word_of(input tdsd_pkg::cmd_type c,
                                                      input logic [15:0] v,
                                                      input logic b,
                                                      input tdsd_pkg::pattern_type l,
                                                      input tdsd_pkg::pattern_type m,
                                                      input tdsd_pkg::pattern_type r);
      tdsd_pkg::req_word_type w;
      w.cmd           = c;
      w.value         = v;
      w.blank_leading = b;
      w.raw_left      = l;
      w.raw_middle    = m;
      w.raw_right     = r;
      return w;
   endfunction

   // applies one accepted word to the display image and queues the pins it leaves
   function automatic void advance_display(input tdsd_pkg::req_word_type w);
      int unsigned n;
      int unsigned p;
      pins_type    pin;
      case (w.cmd)
         tdsd_pkg::CMD_NUMBER: begin
            n = 32'((w.value > tdsd_pkg::NUM_MAX) ? tdsd_pkg::NUM_MAX : w.value);
            shown[0] = (w.blank_leading && n < 100) ? tdsd_pkg::PAT_BLANK : glyph(n / 100);
            shown[1] = (w.blank_leading && n < 10) ? tdsd_pkg::PAT_BLANK
                                                   : glyph((n / 10) % 10);
            shown[2] = glyph(n % 10);
         end
         tdsd_pkg::CMD_TEMP: begin
            n = 32'((w.value > tdsd_pkg::TEMP_MAX) ? tdsd_pkg::TEMP_MAX : w.value);
            shown[0] = glyph(n / 10);
            shown[1] = glyph(n % 10);
            shown[2] = tdsd_pkg::PAT_C;
         end
         tdsd_pkg::CMD_RAW: begin
            shown[0] = w.raw_left;
            shown[1] = w.raw_middle;
            shown[2] = w.raw_right;
         end
         default: begin
            p = (scan_at > 2'd2) ? 2 : 32'(scan_at);
            seg_pins = ~shown[p];
            dig_pins = ~(3'b001 << p);
            scan_at = (p == 2) ? 2'd0 : 2'(p + 1);
         end
      endcase
      pin.segs = seg_pins;
      pin.digs = dig_pins;
      pin_queue.push_back(pin);
   endfunction

   // valid stays high across back-to-back words; dropped only before a gap
   task automatic send_word(input tdsd_pkg::req_word_type w);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.cmd           <= w.cmd;
      req_chan.value         <= w.value;
      req_chan.blank_leading <= w.blank_leading;
      req_chan.raw_left      <= w.raw_left;
      req_chan.raw_middle    <= w.raw_middle;
      req_chan.raw_right     <= w.raw_right;
      do @(posedge clock); while (!req_chan.ready);
      advance_display(w);
   endtask

   task automatic scan_ticks(input int unsigned count);
      repeat (count) send_word(word_of(tdsd_pkg::CMD_SCAN, 16'h0000, 1'b0,
                                       7'h00, 7'h00, 7'h00));
   endtask

   task automatic test_power_on();
      scan_ticks(4);
   endtask

   task automatic test_number_clamp_and_blanking();
      send_word(word_of(tdsd_pkg::CMD_NUMBER, 16'hFFFF, 1'b1, 7'h7F, 7'h7F, 7'h7F));
      scan_ticks(3);
      send_word(word_of(tdsd_pkg::CMD_NUMBER, 16'd7, 1'b1, 7'h00, 7'h00, 7'h00));
      scan_ticks(3);
      send_word(word_of(tdsd_pkg::CMD_NUMBER, 16'd10, 1'b1, 7'h00, 7'h00, 7'h00));
      scan_ticks(3);
      send_word(word_of(tdsd_pkg::CMD_NUMBER, 16'd0, 1'b0, 7'h00, 7'h00, 7'h00));
      scan_ticks(3);
   endtask

   task automatic test_temperature();
      send_word(word_of(tdsd_pkg::CMD_TEMP, 16'hFFFF, 1'b1, 7'h7F, 7'h7F, 7'h7F));
      scan_ticks(3);
   endtask

   task automatic test_raw_patterns();
      send_word(word_of(tdsd_pkg::CMD_RAW, 16'hFFFF, 1'b1, 7'h7F, 7'h00, 7'h55));
      scan_ticks(3);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 9));
         1:       return 16'($urandom_range(0, 99));
         2:       return 16'($urandom_range(95, 105));
         3:       return 16'($urandom_range(0, 999));
         4:       return 16'($urandom_range(990, 1010));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_random_traffic(input int unsigned count);
      tdsd_pkg::req_word_type w;
      int unsigned            sel;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 100 == 0)
            req_calm = ($urandom_range(0, 3) == 0);
         w.value         = pick_value();
         w.blank_leading = 1'($urandom_range(0, 1));
         w.raw_left      = 7'($urandom_range(0, 127));
         w.raw_middle    = 7'($urandom_range(0, 127));
         w.raw_right     = 7'($urandom_range(0, 127));
         sel = $urandom_range(0, 9);
         if (sel < 5)
            w.cmd = tdsd_pkg::CMD_SCAN;
         else if (sel < 7)
            w.cmd = tdsd_pkg::CMD_NUMBER;
         else if (sel < 8)
            w.cmd = tdsd_pkg::CMD_TEMP;
         else
            w.cmd = tdsd_pkg::CMD_RAW;
         send_word(w);
      end
      req_calm = 1'b0;
   endtask

   initial begin : pin_checker
      pins_type    want;
      int unsigned stall;
      int unsigned seen;
      seen = 0;
      while (reset) @(posedge clock);
      forever begin
         if (seen % 64 == 0)
            rsp_calm = ($urandom_range(0, 3) == 0);
         stall = rsp_calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         seen++;
         if (pin_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected word segs=%h digs=%b", $time,
                     rsp_chan.segment_lines, rsp_chan.digit_enables);
         end else begin
            want = pin_queue.pop_front();
            if (rsp_chan.segment_lines !== want.segs) begin
               errors++;
               $display("%0t: segment_lines expected %h got %h", $time,
                        want.segs, rsp_chan.segment_lines);
            end
            if (rsp_chan.digit_enables !== want.digs) begin
               errors++;
               $display("%0t: digit_enables expected %b got %b", $time,
                        want.digs, rsp_chan.digit_enables);
            end
         end
      end
   end

   initial begin
      shown[0] = tdsd_pkg::PATTERNS_RESET[0];
      shown[1] = tdsd_pkg::PATTERNS_RESET[1];
      shown[2] = tdsd_pkg::PATTERNS_RESET[2];
      scan_at  = 2'd0;
      seg_pins = tdsd_pkg::SEG_OFF;
      dig_pins = tdsd_pkg::DIG_OFF;
      req_chan.valid         <= 1'b0;
      req_chan.cmd           <= tdsd_pkg::CMD_NUMBER;
      req_chan.value         <= 16'h0000;
      req_chan.blank_leading <= 1'b0;
      req_chan.raw_left      <= 7'h00;
      req_chan.raw_middle    <= 7'h00;
      req_chan.raw_right     <= 7'h00;
      rsp_chan.ready         <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_power_on();
      test_number_clamp_and_blanking();
      test_temperature();
      test_raw_patterns();
      test_random_traffic(1070);
      req_chan.valid <= 1'b0;
      while (pin_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0 && pin_queue.size() == 0)
         $display("** three_digit_seven_segment_driver_top: PASSED **");
      else
         $display("** three_digit_seven_segment_driver_top: FAILED **");
      $finish;
   end

endmodule
